// ===== rtl/silu_bwd_pkg.sv =====
// Shared widths, constants and the sigmoid breakpoint table for the SiLU backward block.
`default_nettype none

package silu_bwd_pkg;

   // Fixed-point formats of the ports and of the internal datapath.
   localparam int DataWidth  = 16;
   localparam int FracBits   = 12;
   localparam int SigFrac    = 16;
   localparam int DFrac      = 24;
   localparam int SegBits    = 5;
   localparam int LowBits    = DataWidth - SegBits;
   localparam int PadBits    = SigFrac - LowBits;
   localparam int RomWidth   = 16;
   localparam int SlopeWidth = 13;
   localparam int IpWidth    = SlopeWidth + SigFrac;
   localparam int PWidth     = 31;
   localparam int TermWidth  = 48;
   localparam int DWidth     = TermWidth - (FracBits + 8);
   localparam int ProdWidth  = DWidth + DataWidth;
   localparam int RWidth     = ProdWidth - DFrac;
   localparam int Latency    = 8;

   localparam logic [IpWidth:0]            IP_HALF   = (IpWidth + 1)'(1) << (SigFrac - 1);
   localparam logic signed [TermWidth-1:0] TERM_HALF = TermWidth'(1) << (FracBits + 7);
   localparam logic signed [ProdWidth-1:0] PROD_HALF = ProdWidth'(1) << (DFrac - 1);
   localparam logic [SigFrac:0]            SIG_ONE   = (SigFrac + 1)'(1) << SigFrac;
   localparam logic signed [DataWidth-1:0] DATA_MAX  = {1'b0, {(DataWidth - 1){1'b1}}};
   localparam logic signed [DataWidth-1:0] DATA_MIN  = {1'b1, {(DataWidth - 1){1'b0}}};

   typedef logic signed [DataWidth-1:0] data_type;

   // Sigmoid at -8 + k/2 for k = 0..32, unsigned Q0.16, rounded to nearest.
   function automatic logic [RomWidth-1:0] sig_rom(input logic [SegBits:0] idx);
      logic [RomWidth-1:0] val;
      case (idx)
         6'd0:  val = 16'd22;
         6'd1:  val = 16'd36;
         6'd2:  val = 16'd60;
         6'd3:  val = 16'd98;
         6'd4:  val = 16'd162;
         6'd5:  val = 16'd267;
         6'd6:  val = 16'd439;
         6'd7:  val = 16'd720;
         6'd8:  val = 16'd1179;
         6'd9:  val = 16'd1921;
         6'd10: val = 16'd3108;
         6'd11: val = 16'd4971;
         6'd12: val = 16'd7812;
         6'd13: val = 16'd11955;
         6'd14: val = 16'd17625;
         6'd15: val = 16'd24743;
         6'd16: val = 16'd32768;
         6'd17: val = 16'd40793;
         6'd18: val = 16'd47911;
         6'd19: val = 16'd53581;
         6'd20: val = 16'd57724;
         6'd21: val = 16'd60565;
         6'd22: val = 16'd62428;
         6'd23: val = 16'd63615;
         6'd24: val = 16'd64357;
         6'd25: val = 16'd64816;
         6'd26: val = 16'd65097;
         6'd27: val = 16'd65269;
         6'd28: val = 16'd65374;
         6'd29: val = 16'd65438;
         6'd30: val = 16'd65476;
         6'd31: val = 16'd65500;
         6'd32: val = 16'd65514;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/silu_backward_gradient.sv =====
// SiLU backward gradient: input_grad = g * (s + x*s*(1-s)), s = table sigmoid of x.
// Each request runs through the eight registered stages below; rsp_strobe is high in the
// cycle in which that request's result is on rsp_input_grad and rsp_saturated.
// Throughput: one request per cycle, every cycle; busy is never asserted because the
// eight-stage datapath has no loop and the receiver cannot stall the result port.
// Reset (synchronous, active high) clears the stage valid bits; data registers keep
// whatever they hold and are ignored until a valid bit reaches them.
`default_nettype none

module silu_backward_gradient (
   input  wire  logic                                   clock,
   input  wire  logic                                   reset,
   input  wire  logic                                   start,
   output logic                                         busy,
   input  wire  logic signed [silu_bwd_pkg::DataWidth-1:0] req_activation,
   input  wire  logic signed [silu_bwd_pkg::DataWidth-1:0] req_upstream_grad,
   output logic                                         rsp_strobe,
   output logic signed [silu_bwd_pkg::DataWidth-1:0]    rsp_input_grad,
   output logic                                         rsp_saturated
);

   logic                                   accept;
   logic [silu_bwd_pkg::Latency-1:0]       vld_ff, vld_in;

   // Stage 1: table lookup.
   logic [silu_bwd_pkg::DataWidth-1:0]     offset;
   logic [silu_bwd_pkg::SegBits-1:0]       seg;
   logic [silu_bwd_pkg::RomWidth-1:0]      rom_lo, rom_hi;
   logic [silu_bwd_pkg::RomWidth-1:0]      lo1_ff, lo1_in;
   logic [silu_bwd_pkg::SlopeWidth-1:0]    slope1_ff, slope1_in;
   logic [silu_bwd_pkg::SigFrac-1:0]       frac1_ff, frac1_in;
   silu_bwd_pkg::data_type                 x1_ff, g1_ff;

   // Stage 2: interpolation product.
   logic [silu_bwd_pkg::RomWidth-1:0]      lo2_ff;
   logic [silu_bwd_pkg::IpWidth-1:0]       ip2_ff, ip2_in;
   silu_bwd_pkg::data_type                 x2_ff, g2_ff;

   // Stage 3: sigmoid value.
   logic [silu_bwd_pkg::IpWidth:0]         ip_rnd;
   logic [silu_bwd_pkg::SigFrac-1:0]       s3_ff, s3_in;
   silu_bwd_pkg::data_type                 x3_ff, g3_ff;

   // Stage 4: s*(1-s).
   logic [silu_bwd_pkg::SigFrac:0]         s_ext, one_minus;
   logic [2*silu_bwd_pkg::SigFrac+1:0]     p_full;
   logic [silu_bwd_pkg::PWidth-1:0]        p4_ff, p4_in;
   logic [silu_bwd_pkg::SigFrac-1:0]       s4_ff;
   silu_bwd_pkg::data_type                 x4_ff, g4_ff;

   // Stage 5: x*s*(1-s).
   logic signed [silu_bwd_pkg::PWidth:0]   p_signed;
   logic signed [silu_bwd_pkg::TermWidth-1:0] term5_ff, term5_in;
   logic [silu_bwd_pkg::SigFrac-1:0]       s5_ff;
   silu_bwd_pkg::data_type                 g5_ff;

   // Stage 6: derivative d.
   logic signed [silu_bwd_pkg::TermWidth-1:0] term_rnd;
   logic signed [silu_bwd_pkg::DWidth-1:0]    d6_ff, d6_in;
   silu_bwd_pkg::data_type                    g6_ff;

   // Stage 7: d*g.
   logic signed [silu_bwd_pkg::ProdWidth-1:0] prod7_ff, prod7_in;

   // Stage 8: round and saturate.
   logic signed [silu_bwd_pkg::ProdWidth-1:0] prod_rnd;
   logic signed [silu_bwd_pkg::RWidth-1:0]    r_val;
   logic [silu_bwd_pkg::RWidth-silu_bwd_pkg::DataWidth:0] r_top;
   logic                                       over;
   silu_bwd_pkg::data_type                     grad8_ff, grad8_in;
   logic                                       sat8_ff, sat8_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[silu_bwd_pkg::Latency-2:0], accept};

   always_comb begin
      // Q4.12 covers [-8, 8) exactly, so the input never leaves the table range.
      offset    = {~req_activation[silu_bwd_pkg::DataWidth-1],
                   req_activation[silu_bwd_pkg::DataWidth-2:0]};
      seg       = offset[silu_bwd_pkg::DataWidth-1 -: silu_bwd_pkg::SegBits];
      rom_lo    = silu_bwd_pkg::sig_rom({1'b0, seg});
      rom_hi    = silu_bwd_pkg::sig_rom({1'b0, seg} + (silu_bwd_pkg::SegBits + 1)'(1));
      lo1_in    = rom_lo;
      slope1_in = silu_bwd_pkg::SlopeWidth'(rom_hi - rom_lo);
      frac1_in  = {offset[silu_bwd_pkg::LowBits-1:0], {silu_bwd_pkg::PadBits{1'b0}}};

      ip2_in    = silu_bwd_pkg::IpWidth'(slope1_ff) * silu_bwd_pkg::IpWidth'(frac1_ff);

      ip_rnd    = {1'b0, ip2_ff} + silu_bwd_pkg::IP_HALF;
      s3_in     = lo2_ff + silu_bwd_pkg::SigFrac'(ip_rnd >> silu_bwd_pkg::SigFrac);

      s_ext     = {1'b0, s3_ff};
      one_minus = silu_bwd_pkg::SIG_ONE - s_ext;
      p_full    = s_ext * one_minus;
      p4_in     = p_full[silu_bwd_pkg::PWidth-1:0];

      p_signed  = $signed({1'b0, p4_ff});
      term5_in  = x4_ff * p_signed;

      term_rnd  = term5_ff + silu_bwd_pkg::TERM_HALF;
      d6_in     = $signed(term_rnd[silu_bwd_pkg::TermWidth-1:silu_bwd_pkg::FracBits+8])
                  + $signed({4'b0000, s5_ff, 8'b0000_0000});

      prod7_in  = d6_ff * g6_ff;

      prod_rnd  = prod7_ff + silu_bwd_pkg::PROD_HALF;
      r_val     = prod_rnd[silu_bwd_pkg::ProdWidth-1:silu_bwd_pkg::DFrac];
      r_top     = r_val[silu_bwd_pkg::RWidth-1:silu_bwd_pkg::DataWidth-1];
      over      = (r_top != '0) && (r_top != '1);
      sat8_in   = over;
      if (!over) begin
         grad8_in = r_val[silu_bwd_pkg::DataWidth-1:0];
      end else if (r_val[silu_bwd_pkg::RWidth-1]) begin
         grad8_in = silu_bwd_pkg::DATA_MIN;
      end else begin
         grad8_in = silu_bwd_pkg::DATA_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lo1_ff    <= lo1_in;
      slope1_ff <= slope1_in;
      frac1_ff  <= frac1_in;
      x1_ff     <= req_activation;
      g1_ff     <= req_upstream_grad;

      lo2_ff    <= lo1_ff;
      ip2_ff    <= ip2_in;
      x2_ff     <= x1_ff;
      g2_ff     <= g1_ff;

      s3_ff     <= s3_in;
      x3_ff     <= x2_ff;
      g3_ff     <= g2_ff;

      p4_ff     <= p4_in;
      s4_ff     <= s3_ff;
      x4_ff     <= x3_ff;
      g4_ff     <= g3_ff;

      term5_ff  <= term5_in;
      s5_ff     <= s4_ff;
      g5_ff     <= g4_ff;

      d6_ff     <= d6_in;
      g6_ff     <= g5_ff;

      prod7_ff  <= prod7_in;

      grad8_ff  <= grad8_in;
      sat8_ff   <= sat8_in;
   end

   assign rsp_strobe     = vld_ff[silu_bwd_pkg::Latency-1];
   assign rsp_input_grad = grad8_ff;
   assign rsp_saturated  = sat8_ff;

   // Every accepted request produces a result strobe once it has passed through all the stages.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(silu_bwd_pkg::Latency) rsp_strobe)
      else $error("request did not produce a result at the pipeline depth");

   // No result appears without a matching request on start that went through all the stages.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, silu_bwd_pkg::Latency))
      else $error("result strobe without a matching request");

   // A saturated result sits at one of the two signed extremes.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_input_grad == silu_bwd_pkg::DATA_MAX || rsp_input_grad == silu_bwd_pkg::DATA_MIN))
      else $error("saturation flag set on a value that is not clamped");

endmodule

`default_nettype wire
